// ===== sv/qcpe_pkg.sv =====
// Shared types and constants for the quadratic curve point evaluator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package qcpe_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int RESULT_BITS_DEF = 16;
  localparam int YW              = 13;  // knot row width

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KNOT_X0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KNOT_X1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KNOT_X2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KNOT_Y0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KNOT_Y1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KNOT_Y2 = 3'd5;

  // side data that rides along with a transaction through the pipeline
  typedef struct packed {
    logic signed [YW-1:0] y0;
    logic                 degen;
  } qcpe_meta_t;

endpackage

// ===== sv/quadratic_curve_point_eval.sv =====
// Top level of the quadratic curve point evaluator: knot registers, the
// polynomial and divider pipelines, and the output register. Depends on
// qcpe_pkg, qcpe_poly and qcpe_div.
//
// Usage: write the six knot registers through the cfg_ port (index 0..5:
// knot_x0, knot_x1, knot_x2, knot_y0, knot_y1, knot_y2; cfg_ready is always
// high, other indexes are ignored). Then stream columns on the in_ channel.
// Each transaction yields one result on the out_ channel, in order.
// The path runs through five stages of differences, multipliers and the
// numerator sum, a magnitude stage, a load stage, one stage per quotient
// bit of the restoring divider, and the output register.
// Throughput is one column per cycle while in_stall is low; the divider is
// fully pipelined, one quotient bit per stage.
// Reset clears all valid bits and sets the knots to x = 0, 1, 2 and y = 0.
// When the receiver stalls, the output register holds its result; the
// pipeline keeps advancing and taking columns until its last stage holds a
// result that cannot move, then in_stall rises. Nothing is dropped or repeated.
`timescale 1ns / 1ps
module quadratic_curve_point_eval #(
  parameter int COORD_BITS  = qcpe_pkg::COORD_BITS_DEF,
  parameter int RESULT_BITS = qcpe_pkg::RESULT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qcpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [((COORD_BITS > qcpe_pkg::YW) ? COORD_BITS : qcpe_pkg::YW)-1:0]
                                           cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [COORD_BITS-1:0]            in_column,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [RESULT_BITS-1:0]    out_curve_y,
  output logic                             out_fallback_used,
  output logic                             out_saturated,
  output logic                             out_knots_degenerate
);
  import qcpe_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int RB  = RESULT_BITS;
  localparam int DNW = 3 * (CB + 1);
  localparam int NW  = DNW + YW + 2;
  localparam int EW  = (RB > YW) ? RB : YW;
  localparam logic signed [RB-1:0] MAXR = {1'b0, {(RB-1){1'b1}}};
  localparam logic signed [RB-1:0] MINR = {1'b1, {(RB-1){1'b0}}};

  logic [CB-1:0] knot_x0_r, knot_x1_r, knot_x2_r;
  logic signed [YW-1:0] knot_y0_r, knot_y1_r, knot_y2_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knot_x0_r <= CB'(0);
      knot_x1_r <= CB'(1);
      knot_x2_r <= CB'(2);
      knot_y0_r <= '0;
      knot_y1_r <= '0;
      knot_y2_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KNOT_X0: knot_x0_r <= cfg_data[CB-1:0];
        REG_KNOT_X1: knot_x1_r <= cfg_data[CB-1:0];
        REG_KNOT_X2: knot_x2_r <= cfg_data[CB-1:0];
        REG_KNOT_Y0: knot_y0_r <= cfg_data[YW-1:0];
        REG_KNOT_Y1: knot_y1_r <= cfg_data[YW-1:0];
        REG_KNOT_Y2: knot_y2_r <= cfg_data[YW-1:0];
        default: ;
      endcase
    end
  end

  logic out_valid_r, out_valid_nxt;

  // pipeline advance: stop only when the last stage holds a result and the
  // output register is full and stalled
  logic en, out_ld;
  logic pv;
  logic signed [NW-1:0] p_num;
  logic signed [DNW-1:0] p_den;
  qcpe_meta_t p_meta, d_meta;
  logic dv, d_ovf, d_fb;
  logic [RB-2:0] d_quo;

  assign out_ld   = !(out_valid_r && out_stall);
  assign en       = out_ld || !dv;
  assign in_stall = !en;

  qcpe_poly #(.CB(CB), .NW(NW), .DNW(DNW)) u_poly (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(in_valid),
    .column(in_column), .x0(knot_x0_r), .x1(knot_x1_r), .x2(knot_x2_r),
    .y0(knot_y0_r), .y1(knot_y1_r), .y2(knot_y2_r),
    .v_out(pv), .num(p_num), .den(p_den), .meta(p_meta)
  );

  qcpe_div #(.NW(NW), .DNW(DNW), .RB(RB)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .v_in(pv),
    .num(p_num), .den(p_den), .meta_in(p_meta),
    .v_out(dv), .quo(d_quo), .ovf(d_ovf), .below_one(d_fb), .meta_out(d_meta)
  );

  // result selection
  logic signed [EW-1:0] y0e;
  logic signed [RB-1:0] y_nxt;
  logic fb_nxt, sat_nxt;

  assign y0e = EW'(d_meta.y0);

  always_comb begin
    y_nxt   = '0;
    fb_nxt  = 1'b0;
    sat_nxt = 1'b0;
    if (d_meta.degen) begin
      y_nxt = '0;
    end else if (d_fb) begin
      fb_nxt = 1'b1;
      if (y0e > EW'(MAXR)) begin
        y_nxt   = MAXR;
        sat_nxt = 1'b1;
      end else if (y0e < EW'(MINR)) begin
        y_nxt   = MINR;
        sat_nxt = 1'b1;
      end else begin
        y_nxt = y0e[RB-1:0];
      end
    end else if (d_ovf) begin
      y_nxt   = MAXR;
      sat_nxt = 1'b1;
    end else begin
      y_nxt = {1'b0, d_quo};
    end
  end

  logic signed [RB-1:0] out_y_r;
  logic out_fb_r, out_sat_r, out_deg_r;

  assign out_valid_nxt = out_ld ? dv : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld && dv) begin
      out_y_r   <= y_nxt;
      out_fb_r  <= fb_nxt;
      out_sat_r <= sat_nxt;
      out_deg_r <= d_meta.degen;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_curve_y          = out_y_r;
  assign out_fallback_used    = out_fb_r;
  assign out_saturated        = out_sat_r;
  assign out_knots_degenerate = out_deg_r;

`ifndef SYNTH
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_knots_degenerate |->
      out_curve_y == '0 && !out_fallback_used && !out_saturated)
    else $error("degenerate knots must give a zero result");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated && !out_fallback_used |-> out_curve_y == MAXR)
    else $error("quotient saturation must give the maximum");

  a_quo_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fallback_used && !out_knots_degenerate |->
      !out_curve_y[RB-1] && out_curve_y != '0)
    else $error("a quotient result must be at least one");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output");
`endif

endmodule

// ===== sv/qcpe_poly.sv =====
// Numerator and common denominator of the quadratic Lagrange form, 5 stages.
// Depends on qcpe_pkg.
`timescale 1ns / 1ps
module qcpe_poly #(
  parameter int CB = 12,
  parameter int NW = 3 * (CB + 1) + 15,
  parameter int DNW = 3 * (CB + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     v_in,
  input  logic [CB-1:0]            column,
  input  logic [CB-1:0]            x0,
  input  logic [CB-1:0]            x1,
  input  logic [CB-1:0]            x2,
  input  logic signed [qcpe_pkg::YW-1:0] y0,
  input  logic signed [qcpe_pkg::YW-1:0] y1,
  input  logic signed [qcpe_pkg::YW-1:0] y2,
  output logic                     v_out,
  output logic signed [NW-1:0]     num,
  output logic signed [DNW-1:0]    den,
  output qcpe_pkg::qcpe_meta_t     meta
);
  import qcpe_pkg::*;

  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int TW = 3 * DW;
  localparam int TN = TW + YW;

  logic [4:0] v_r;
  qcpe_meta_t m1_r, m2_r, m3_r, m4_r, m5_r;

  // stage 1
  logic signed [DW-1:0] a0_r, a1_r, a2_r, d01_r, d02_r, d12_r;
  logic signed [YW-1:0] y1_1r, y2_1r;
  // stage 2
  logic signed [PW-1:0] p0_r, p1_r, p2_r, dd_r;
  logic signed [DW-1:0] d01_2r, d02_2r, d12_2r;
  logic signed [YW-1:0] y1_2r, y2_2r;
  // stage 3
  logic signed [TW-1:0] t0_r, t1_r, t2_r, den3_r;
  logic signed [YW-1:0] y1_3r, y2_3r;
  // stage 4
  logic signed [TN-1:0] n0_r, n1_r, n2_r;
  logic signed [DNW-1:0] den4_r;
  // stage 5
  logic signed [NW-1:0] num_r;
  logic signed [DNW-1:0] den5_r;

  logic [4:0] v_nxt;
  assign v_nxt = {v_r[3:0], v_in};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r  <= $signed({1'b0, column}) - $signed({1'b0, x0});
      a1_r  <= $signed({1'b0, column}) - $signed({1'b0, x1});
      a2_r  <= $signed({1'b0, column}) - $signed({1'b0, x2});
      d01_r <= $signed({1'b0, x0}) - $signed({1'b0, x1});
      d02_r <= $signed({1'b0, x0}) - $signed({1'b0, x2});
      d12_r <= $signed({1'b0, x1}) - $signed({1'b0, x2});
      y1_1r <= y1;
      y2_1r <= y2;
      m1_r.y0    <= y0;
      m1_r.degen <= (x0 == x1) || (x0 == x2) || (x1 == x2);

      p0_r   <= PW'(a1_r) * PW'(a2_r);
      p1_r   <= PW'(a0_r) * PW'(a2_r);
      p2_r   <= PW'(a0_r) * PW'(a1_r);
      dd_r   <= PW'(d01_r) * PW'(d02_r);
      d01_2r <= d01_r;
      d02_2r <= d02_r;
      d12_2r <= d12_r;
      y1_2r  <= y1_1r;
      y2_2r  <= y2_1r;
      m2_r   <= m1_r;

      t0_r   <= TW'(p0_r) * TW'(d12_2r);
      t1_r   <= TW'(p1_r) * TW'(d02_2r);
      t2_r   <= TW'(p2_r) * TW'(d01_2r);
      den3_r <= TW'(dd_r) * TW'(d12_2r);
      y1_3r  <= y1_2r;
      y2_3r  <= y2_2r;
      m3_r   <= m2_r;

      n0_r   <= TN'(m3_r.y0) * TN'(t0_r);
      n1_r   <= TN'(y1_3r) * TN'(t1_r);
      n2_r   <= TN'(y2_3r) * TN'(t2_r);
      den4_r <= DNW'(den3_r);
      m4_r   <= m3_r;

      num_r  <= NW'(n0_r) - NW'(n1_r) + NW'(n2_r);
      den5_r <= den4_r;
      m5_r   <= m4_r;
    end
  end

  assign v_out = v_r[4];
  assign num   = num_r;
  assign den   = den5_r;
  assign meta  = m5_r;

endmodule

// ===== sv/qcpe_div.sv =====
// Pipelined restoring divider for |num| / |den|, one quotient bit per stage,
// with overflow (quotient above the result range) and negative or below-one detection.
// Depends on qcpe_pkg.
`timescale 1ns / 1ps
module qcpe_div #(
  parameter int NW = 54,
  parameter int DNW = 39,
  parameter int RB = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  v_in,
  input  logic signed [NW-1:0]  num,
  input  logic signed [DNW-1:0] den,
  input  qcpe_pkg::qcpe_meta_t  meta_in,
  output logic                  v_out,
  output logic [RB-2:0]         quo,
  output logic                  ovf,
  output logic                  below_one,
  output qcpe_pkg::qcpe_meta_t  meta_out
);
  import qcpe_pkg::*;

  localparam int CW = NW + RB;
  localparam int QW = RB - 1;
  localparam int NS = RB;  // stage 0 is the load stage, then QW step stages

  // magnitude stage
  logic          va_r;
  logic [NW-1:0] ma_r;
  logic [DNW-1:0] mb_r;
  logic          neg_r;
  qcpe_meta_t    ma_meta_r;

  logic [CW-1:0]  rem_r  [NS];
  logic [DNW-1:0] b_r    [NS];
  logic [QW-1:0]  q_r    [NS];
  logic           v_r    [NS];
  logic           ovf_r  [NS];
  logic           fb_r   [NS];
  qcpe_meta_t     meta_r [NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r      <= num[NW-1] ? NW'(-num) : NW'(num);
      mb_r      <= den[DNW-1] ? DNW'(-den) : DNW'(den);
      neg_r     <= num[NW-1] ^ den[DNW-1];
      ma_meta_r <= meta_in;
    end
  end

  // load stage: range checks and initial remainder
  logic [CW-1:0] a_ext, b_top;
  assign a_ext = CW'(ma_r);
  assign b_top = CW'(mb_r) << QW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= a_ext;
      b_r[0]    <= mb_r;
      q_r[0]    <= '0;
      ovf_r[0]  <= a_ext >= b_top;
      fb_r[0]   <= neg_r || (ma_r < NW'(mb_r));
      meta_r[0] <= ma_meta_r;
    end
  end

  for (genvar j = 1; j < NS; j++) begin : g_step
    localparam int K = QW - j;
    logic [CW-1:0] sh;
    logic          ge;
    assign sh = CW'(b_r[j-1]) << K;
    assign ge = rem_r[j-1] >= sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= ge ? (rem_r[j-1] - sh) : rem_r[j-1];
        q_r[j]    <= {q_r[j-1][QW-2:0], ge};
        b_r[j]    <= b_r[j-1];
        ovf_r[j]  <= ovf_r[j-1];
        fb_r[j]   <= fb_r[j-1];
        meta_r[j] <= meta_r[j-1];
      end
    end
  end

  assign v_out     = v_r[NS-1];
  assign quo       = q_r[NS-1];
  assign ovf       = ovf_r[NS-1];
  assign below_one = fb_r[NS-1];
  assign meta_out  = meta_r[NS-1];

endmodule
